@@ src/btvm_pkg.sv @@
// ----------------------------------------------------------------------------
// btvm_pkg
// Request codes, status codes and the token that walks the cell chain.
// ----------------------------------------------------------------------------
package btvm_pkg;

   localparam int KEY_W    = 32;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int CAP_W    = 5;
   localparam int HITS_W   = 2;

   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;

   localparam logic [HITS_W-1:0] HITS_NONE = 2'd0;
   localparam logic [HITS_W-1:0] HITS_ONE  = 2'd1;
   localparam logic [HITS_W-1:0] HITS_TWO  = 2'd2;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef struct packed {
      logic                    active;
      logic [KIND_W-1:0]       kind;
      logic signed [KEY_W-1:0] key;
      logic signed [KEY_W-1:0] value;
      logic                    full;
      logic [HITS_W-1:0]       hits;
      logic signed [KEY_W-1:0] first_value;
      logic signed [KEY_W-1:0] second_value;
      logic                    removed;
   } token_type;

endpackage

@@ src/btvm_cell.sv @@
// ----------------------------------------------------------------------------
// btvm_cell
// One table slot: holds a key/value pair and updates the passing token.
// ----------------------------------------------------------------------------
module btvm_cell #(
   parameter int INDEX   = 0,
   parameter int OCC_W   = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [OCC_W-1:0]                 occupancy,
   input  btvm_pkg::token_type              tok_in,
   input  logic signed [btvm_pkg::KEY_W-1:0] next_key,
   input  logic signed [btvm_pkg::KEY_W-1:0] next_value,
   output btvm_pkg::token_type              tok_out,
   output logic signed [btvm_pkg::KEY_W-1:0] key_out,
   output logic signed [btvm_pkg::KEY_W-1:0] value_out
);
   import btvm_pkg::*;

   token_type               tok_ff, tok_in_c;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic signed [KEY_W-1:0] value_ff, value_in;
   logic                    in_use, key_hit, pair_hit, at_tail;

   always_comb begin
      in_use   = occupancy > OCC_W'(INDEX);
      at_tail  = occupancy == OCC_W'(INDEX);
      key_hit  = in_use && (key_ff == tok_in.key);
      pair_hit = key_hit && (value_ff == tok_in.value) && !tok_in.removed;
      tok_in_c = tok_in;
      key_in   = key_ff;
      value_in = value_ff;
      if (tok_in.active) begin
         if (key_hit) begin
            if (tok_in.hits == HITS_NONE) begin
               tok_in_c.first_value = value_ff;
            end
            if (tok_in.hits == HITS_ONE) begin
               tok_in_c.second_value = value_ff;
            end
            if (tok_in.hits != HITS_TWO) begin
               tok_in_c.hits = tok_in.hits + HITS_ONE;
            end
         end
         case (tok_in.kind)
            KIND_ADD: begin
               if (at_tail && !tok_in.full && tok_in.hits != HITS_TWO) begin
                  key_in   = tok_in.key;
                  value_in = tok_in.value;
               end
            end
            KIND_REMOVE: begin
               // close the gap: take the upper neighbor's pair
               if (tok_in.removed || pair_hit) begin
                  key_in   = next_key;
                  value_in = next_value;
               end
               tok_in_c.removed = tok_in.removed | pair_hit;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_c;
      end
   end

   assign tok_out   = tok_ff;
   assign key_out   = key_ff;
   assign value_out = value_ff;

endmodule

@@ src/bounded_two_value_multimap.sv @@
// ----------------------------------------------------------------------------
// bounded_two_value_multimap
// Insertion-ordered key/value table holding at most two values per key.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; it then walks the
// row of DEPTH slot cells, one cell per cycle, and its result appears on the
// rsp_ ports for exactly one cycle with rsp_valid. The request is held in
// token_ff, then in the register of every cell of the chain, and the result
// in the rsp_ registers. busy drops in the cycle the result is shown, so the
// next request may start then. The receiver cannot stall: sample the result
// when rsp_valid is high. Write csr_write_data only while the block is idle.
module bounded_two_value_multimap #(
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [btvm_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [btvm_pkg::KEY_W-1:0]    req_key,
   input  logic signed [btvm_pkg::KEY_W-1:0]    req_value,
   input  logic                                 csr_write_enable,
   input  logic [btvm_pkg::CAP_W-1:0]           csr_write_data,
   output logic                                 rsp_valid,
   output logic [btvm_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [btvm_pkg::KEY_W-1:0]    rsp_first_value,
   output logic                                 rsp_first_found,
   output logic signed [btvm_pkg::KEY_W-1:0]    rsp_second_value,
   output logic                                 rsp_second_found,
   output logic [btvm_pkg::COUNT_W-1:0]         rsp_entry_count,
   output logic                                 rsp_is_empty,
   output logic                                 rsp_is_full
);
   import btvm_pkg::*;

   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   token_type               chain [DEPTH+1];
   logic signed [KEY_W-1:0] cell_key   [DEPTH];
   logic signed [KEY_W-1:0] cell_value [DEPTH];

   token_type               token_ff, token_in;
   logic                    busy_ff, busy_in;
   logic [CAP_W-1:0]        cap_ff, cap_in;
   logic [OCC_W-1:0]        occ_ff, occ_in;
   logic [OCC_W-1:0]        cap_eff;
   logic [CMP_W-1:0]        cap_wide;
   logic                    accept;
   token_type               tail;

   logic                    valid_ff, valid_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic signed [KEY_W-1:0] first_ff, first_in, second_ff, second_in;
   logic                    ffound_ff, ffound_in, sfound_ff, sfound_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic                    empty_ff, empty_in, full_ff, full_in;

   assign accept = start && !busy_ff;

   always_comb begin
      cap_wide = CMP_W'(cap_ff);
      if (cap_ff == '0) begin
         cap_eff = OCC_W'(1);
      end else if (cap_wide > CMP_W'(DEPTH)) begin
         cap_eff = OCC_W'(DEPTH);
      end else begin
         cap_eff = OCC_W'(cap_wide);
      end
   end

   always_comb begin
      token_in        = token_ff;
      token_in.active = 1'b0;
      if (accept) begin
         token_in.active       = 1'b1;
         token_in.kind         = req_kind;
         token_in.key          = req_key;
         token_in.value        = req_value;
         token_in.full         = occ_ff >= cap_eff;
         token_in.hits         = HITS_NONE;
         token_in.first_value  = '0;
         token_in.second_value = '0;
         token_in.removed      = 1'b0;
      end
   end

   assign chain[0] = token_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [KEY_W-1:0] up_key, up_value;
      if (i == DEPTH - 1) begin : g_last
         assign up_key   = cell_key[i];
         assign up_value = cell_value[i];
      end else begin : g_mid
         assign up_key   = cell_key[i+1];
         assign up_value = cell_value[i+1];
      end
      btvm_cell #(
         .INDEX (i),
         .OCC_W (OCC_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .occupancy  (occ_ff),
         .tok_in     (chain[i]),
         .next_key   (up_key),
         .next_value (up_value),
         .tok_out    (chain[i+1]),
         .key_out    (cell_key[i]),
         .value_out  (cell_value[i])
      );
   end

   assign tail = chain[DEPTH];

   always_comb begin
      busy_in   = busy_ff;
      occ_in    = occ_ff;
      cap_in    = csr_write_enable ? csr_write_data : cap_ff;
      valid_in  = tail.active;
      status_in = STATUS_DONE;
      first_in  = '0;
      second_in = '0;
      ffound_in = 1'b0;
      sfound_in = 1'b0;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (tail.active) begin
         busy_in = 1'b0;
         case (tail.kind)
            KIND_ADD: begin
               if (tail.full) begin
                  status_in = STATUS_FULL;
               end else if (tail.hits == HITS_TWO) begin
                  status_in = STATUS_REJECTED;
               end else begin
                  occ_in = occ_ff + OCC_W'(1);
               end
            end
            KIND_SEARCH: begin
               first_in  = tail.first_value;
               second_in = tail.second_value;
               ffound_in = tail.hits != HITS_NONE;
               sfound_in = tail.hits == HITS_TWO;
            end
            KIND_REMOVE: begin
               if (tail.removed) begin
                  occ_in = occ_ff - OCC_W'(1);
               end else begin
                  status_in = STATUS_REJECTED;
               end
            end
            default: begin
            end
         endcase
      end
      count_in = COUNT_W'(occ_in);
      empty_in = occ_in == '0;
      full_in  = occ_in >= cap_eff;
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      ffound_ff <= ffound_in;
      sfound_ff <= sfound_in;
      count_ff  <= count_in;
      empty_ff  <= empty_in;
      full_ff   <= full_in;
      if (reset) begin
         token_ff <= '0;
         busy_ff  <= 1'b0;
         occ_ff   <= '0;
         cap_ff   <= CAP_RESET;
         valid_ff <= 1'b0;
      end else begin
         token_ff <= token_in;
         busy_ff  <= busy_in;
         occ_ff   <= occ_in;
         cap_ff   <= cap_in;
         valid_ff <= valid_in;
      end
   end

   assign busy             = busy_ff;
   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_first_value  = first_ff;
   assign rsp_first_found  = ffound_ff;
   assign rsp_second_value = second_ff;
   assign rsp_second_found = sfound_ff;
   assign rsp_entry_count  = count_ff;
   assign rsp_is_empty     = empty_ff;
   assign rsp_is_full      = full_ff;

endmodule
